FILE: sv/agcm_pkg.sv
`timescale 1ns / 1ps
package agcm_pkg;

  localparam int ROUND_COUNT = 14;
  localparam int BLOCK_BYTES = 16;
  localparam int RK_DEPTH    = ROUND_COUNT + 1;
  localparam int RK_AW       = 4;
  localparam int BLK_W       = 8 * BLOCK_BYTES;
  localparam int TOT_W       = 61;
  localparam logic [RK_AW-1:0] RK_LAST = RK_AW'(ROUND_COUNT);

  localparam logic [1:0] OP_AAD    = 2'd0;
  localparam logic [1:0] OP_TEXT   = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_MISMATCH = 2'd1;
  localparam logic [1:0] STAT_ORDER    = 2'd2;

  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_TAG  = 1'b1;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_AAD  = 2'd1;
  localparam logic [1:0] PH_TEXT = 2'd2;

  localparam logic [2:0] REG_KEY3  = 3'd0;
  localparam logic [2:0] REG_KEY2  = 3'd1;
  localparam logic [2:0] REG_KEY1  = 3'd2;
  localparam logic [2:0] REG_KEY0  = 3'd3;
  localparam logic [2:0] REG_NONCE_HI = 3'd4;
  localparam logic [2:0] REG_NONCE_LO = 3'd5;
  localparam logic [2:0] REG_MODE  = 3'd6;

  localparam logic [7:0] GF_POLY   = 8'h1b;
  localparam logic [7:0] GH_POLY   = 8'he1;

  typedef struct packed {
    logic              start;
    logic [BLK_W-1:0]  data;
  } agcm_req_t;

  typedef struct packed {
    logic              done;
    logic [BLK_W-1:0]  data;
  } agcm_rsp_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] b);
    return SBOX[b];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
  endfunction

  // sub bytes, shift rows and (except in the last round) mix columns
  function automatic logic [BLK_W-1:0] aes_round(input logic [BLK_W-1:0] s, input logic last);
    logic [7:0] sb [16];
    logic [7:0] t  [16];
    logic [7:0] a0, a1, a2, a3;
    logic [BLK_W-1:0] r;
    for (int i = 0; i < 16; i++) sb[i] = sbox(s[BLK_W-1-8*i -: 8]);
    for (int c = 0; c < 4; c++)
      for (int k = 0; k < 4; k++) t[c*4+k] = sb[((c + k) % 4) * 4 + k];
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      if (!last) begin
        t[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        t[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
        t[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
        t[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
    end
    for (int i = 0; i < 16; i++) r[BLK_W-1-8*i -: 8] = t[i];
    return r;
  endfunction

  function automatic logic [BLK_W-1:0] byte_mask(input logic [4:0] n);
    logic [BLK_W-1:0] m;
    for (int i = 0; i < BLOCK_BYTES; i++) m[BLK_W-1-8*i -: 8] = (5'(i) < n) ? 8'hff : 8'h00;
    return m;
  endfunction

endpackage

FILE: sv/agcm_if.sv
`timescale 1ns / 1ps
interface agcm_in_if import agcm_pkg::*;;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [63:0] data_high;
  logic [63:0] data_low;
  logic [4:0]  byte_count;
  modport source (output valid, op, data_high, data_low, byte_count, input ready);
  modport sink   (input valid, op, data_high, data_low, byte_count, output ready);
endinterface

interface agcm_out_if import agcm_pkg::*;;
  logic        valid;
  logic        ready;
  logic [63:0] out_high;
  logic [63:0] out_low;
  logic [4:0]  out_count;
  logic        result_kind;
  logic [1:0]  status;
  modport source (output valid, out_high, out_low, out_count, result_kind, status,
                  input ready);
  modport sink   (input valid, out_high, out_low, out_count, result_kind, status,
                  output ready);
endinterface

interface agcm_cfg_if import agcm_pkg::*;;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/aes256_gcm_seal_open.sv
`timescale 1ns / 1ps
// AES-256-GCM seal/open engine, 96-bit nonce, one 16-byte block per beat.
// cfg_i: register writes (key words, nonce, mode), taken whenever offered;
//   write only while the block is idle. A key write forces re-expansion.
// in_i: op 0 AAD, 1 text, 2 finish with expected tag; byte_count valid bytes.
// out_o: one beat per text item, per finish (tag) and per AAD after text.
// Timing: one item at a time. An AES block takes one round per cycle
//   (round keys read from the key memory) and a GHASH multiply takes one
//   load, then 8 bits per cycle. The first item after a key change first
//   runs key expansion (15 memory writes) and computes H = E(K, 0).
// Reset clears the message state and the registers; the key memory is
//   rewritten before use. A finished result sits in the output register
//   while in_i is ready again; a next result waits until out_o drains.
module aes256_gcm_seal_open import agcm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  agcm_cfg_if.sink    cfg_i,
  agcm_in_if.sink     in_i,
  agcm_out_if.source  out_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_KEXP, S_HKEY, S_DISPATCH, S_AES, S_HASH, S_EMIT
  } state_e;

  state_e           state_q;
  logic [255:0]     key_q;
  logic [63:0]      nonce_hi_q;
  logic [31:0]      nonce_lo_q;
  logic             dec_q, keys_ready_q, fault_q;
  logic [1:0]       phase_q, op_q;
  logic [BLK_W-1:0] data_q, h_q, acc_q, res_q;
  logic [4:0]       n_q, res_cnt_q, n_sat;
  logic             res_kind_q;
  logic [1:0]       res_stat_q;
  logic [31:0]      ctr_q;
  logic [TOT_W-1:0] aad_q, text_q;
  logic             out_valid_q;
  logic             kx_start_q;
  agcm_req_t        aes_req_q, gh_req_q;
  agcm_rsp_t        aes_rsp, gh_rsp;
  logic             kx_we, kx_done;
  logic [RK_AW-1:0] kx_waddr, rk_raddr;
  logic [BLK_W-1:0] kx_wdata, rk_rdata, in_data, ks_text, tag;
  logic             in_acc;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && (state_q == S_IDLE);
  assign n_sat       = (in_i.byte_count > 5'd16) ? 5'd16 : in_i.byte_count;
  assign in_data     = {in_i.data_high, in_i.data_low};
  assign ks_text     = (data_q ^ aes_rsp.data) & byte_mask(n_q);
  assign tag         = acc_q ^ aes_rsp.data;
  assign out_o.valid = out_valid_q;

  agcm_ram #(.WIDTH(BLK_W), .DEPTH(RK_DEPTH)) u_rk_ram (
    .clk_i, .we_i(kx_we), .waddr_i(kx_waddr), .wdata_i(kx_wdata),
    .raddr_i(rk_raddr), .rdata_o(rk_rdata)
  );

  agcm_keyexp u_kx (
    .clk_i, .rst_ni, .start_i(kx_start_q), .key_i(key_q),
    .we_o(kx_we), .waddr_o(kx_waddr), .wdata_o(kx_wdata), .done_o(kx_done)
  );

  agcm_aes u_aes (
    .clk_i, .rst_ni, .req_i(aes_req_q), .raddr_o(rk_raddr), .rk_i(rk_rdata), .rsp_o(aes_rsp)
  );

  agcm_ghash u_gh (
    .clk_i, .rst_ni, .req_i(gh_req_q), .h_i(h_q), .rsp_o(gh_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      key_q           <= '0;
      nonce_hi_q      <= '0;
      nonce_lo_q      <= '0;
      dec_q           <= 1'b0;
      keys_ready_q    <= 1'b0;
      fault_q         <= 1'b0;
      phase_q         <= PH_IDLE;
      acc_q           <= '0;
      ctr_q           <= 32'd1;
      aad_q           <= '0;
      text_q          <= '0;
      out_valid_q     <= 1'b0;
      kx_start_q      <= 1'b0;
      aes_req_q.start <= 1'b0;
      gh_req_q.start  <= 1'b0;
    end else begin
      kx_start_q      <= 1'b0;
      aes_req_q.start <= 1'b0;
      gh_req_q.start  <= 1'b0;
      if (out_valid_q && out_o.ready) out_valid_q <= 1'b0;

      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          REG_KEY3:     begin key_q[255:192] <= cfg_i.data; keys_ready_q <= 1'b0; end
          REG_KEY2:     begin key_q[191:128] <= cfg_i.data; keys_ready_q <= 1'b0; end
          REG_KEY1:     begin key_q[127:64]  <= cfg_i.data; keys_ready_q <= 1'b0; end
          REG_KEY0:     begin key_q[63:0]    <= cfg_i.data; keys_ready_q <= 1'b0; end
          REG_NONCE_HI: nonce_hi_q <= cfg_i.data;
          REG_NONCE_LO: nonce_lo_q <= cfg_i.data[31:0];
          REG_MODE:     dec_q      <= cfg_i.data[0];
          default: ;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc && in_i.op != OP_NONE) begin
            op_q   <= in_i.op;
            n_q    <= n_sat;
            // the finish compare uses the full expected tag
            data_q <= (in_i.op == OP_FINISH) ? in_data : (in_data & byte_mask(n_sat));
            if (!keys_ready_q) begin
              kx_start_q <= 1'b1;
              state_q    <= S_KEXP;
            end else begin
              state_q <= S_DISPATCH;
            end
          end
        end
        S_KEXP: begin
          if (kx_done) begin
            aes_req_q.start <= 1'b1;
            aes_req_q.data  <= '0;
            state_q         <= S_HKEY;
          end
        end
        S_HKEY: begin
          if (aes_rsp.done) begin
            h_q          <= aes_rsp.data;
            keys_ready_q <= 1'b1;
            state_q      <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          res_q      <= '0;
          res_cnt_q  <= 5'd0;
          res_kind_q <= KIND_TEXT;
          res_stat_q <= STAT_OK;
          unique case (op_q)
            OP_AAD: begin
              if (phase_q == PH_TEXT) begin
                fault_q    <= 1'b1;
                res_stat_q <= STAT_ORDER;
                state_q    <= S_EMIT;
              end else begin
                phase_q <= PH_AAD;
                if (n_q != 5'd0) begin
                  gh_req_q.start <= 1'b1;
                  gh_req_q.data  <= acc_q ^ data_q;
                  aad_q          <= aad_q + TOT_W'(n_q);
                  state_q        <= S_HASH;
                end else begin
                  state_q <= S_IDLE;
                end
              end
            end
            OP_TEXT: begin
              phase_q <= PH_TEXT;
              if (n_q == 5'd0) begin
                state_q <= S_EMIT;
              end else begin
                ctr_q           <= ctr_q + 32'd1;
                aes_req_q.start <= 1'b1;
                aes_req_q.data  <= {nonce_hi_q, nonce_lo_q, ctr_q + 32'd1};
                state_q         <= S_AES;
              end
            end
            default: begin
              gh_req_q.start <= 1'b1;
              gh_req_q.data  <= acc_q ^ {aad_q, 3'b000, text_q, 3'b000};
              state_q        <= S_HASH;
            end
          endcase
        end
        S_AES: begin
          if (aes_rsp.done) begin
            if (op_q == OP_TEXT) begin
              res_q          <= ks_text;
              res_cnt_q      <= n_q;
              gh_req_q.start <= 1'b1;
              gh_req_q.data  <= acc_q ^ (dec_q ? data_q : ks_text);
              text_q         <= text_q + TOT_W'(n_q);
              state_q        <= S_HASH;
            end else begin
              res_q      <= tag;
              res_cnt_q  <= 5'd16;
              res_kind_q <= KIND_TAG;
              if (fault_q)                    res_stat_q <= STAT_ORDER;
              else if (dec_q && tag != data_q) res_stat_q <= STAT_MISMATCH;
              else                            res_stat_q <= STAT_OK;
              acc_q   <= '0;
              ctr_q   <= 32'd1;
              aad_q   <= '0;
              text_q  <= '0;
              phase_q <= PH_IDLE;
              fault_q <= 1'b0;
              state_q <= S_EMIT;
            end
          end
        end
        S_HASH: begin
          if (gh_rsp.done) begin
            acc_q <= gh_rsp.data;
            unique case (op_q)
              OP_AAD:  state_q <= S_IDLE;
              OP_TEXT: state_q <= S_EMIT;
              default: begin
                aes_req_q.start <= 1'b1;
                aes_req_q.data  <= {nonce_hi_q, nonce_lo_q, 32'd1};
                state_q         <= S_AES;
              end
            endcase
          end
        end
        S_EMIT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q       <= 1'b1;
            out_o.out_high    <= res_q[127:64];
            out_o.out_low     <= res_q[63:0];
            out_o.out_count   <= res_cnt_q;
            out_o.result_kind <= res_kind_q;
            out_o.status      <= res_stat_q;
            state_q           <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: sv/agcm_ram.sv
`timescale 1ns / 1ps
module agcm_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 15,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: sv/agcm_keyexp.sv
`timescale 1ns / 1ps
module agcm_keyexp import agcm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [255:0]      key_i,
  output logic              we_o,
  output logic [RK_AW-1:0]  waddr_o,
  output logic [BLK_W-1:0]  wdata_o,
  output logic              done_o
);
  logic             busy_q, done_q;
  logic [RK_AW-1:0] cnt_q;
  logic [BLK_W-1:0] kp2_q, kp1_q;
  logic [7:0]       rcon_q;
  logic [31:0]      t, w0, w1, w2, w3;

  always_comb begin
    t = kp1_q[31:0];
    if (!cnt_q[0]) begin
      t = {sbox(t[23:16]) ^ rcon_q, sbox(t[15:8]), sbox(t[7:0]), sbox(t[31:24])};
    end else begin
      t = {sbox(t[31:24]), sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0])};
    end
    w0 = kp2_q[127:96] ^ t;
    w1 = kp2_q[95:64]  ^ w0;
    w2 = kp2_q[63:32]  ^ w1;
    w3 = kp2_q[31:0]   ^ w2;
    priority case (1'b1)
      cnt_q == '0:            wdata_o = key_i[255:128];
      cnt_q == RK_AW'(1):     wdata_o = key_i[127:0];
      default:                wdata_o = {w0, w1, w2, w3};
    endcase
  end

  assign we_o    = busy_q;
  assign waddr_o = cnt_q;
  assign done_o  = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rcon_q <= 8'h01;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rcon_q <= 8'h01;
      end else if (busy_q) begin
        kp2_q <= kp1_q;
        kp1_q <= wdata_o;
        cnt_q <= cnt_q + RK_AW'(1);
        if (cnt_q > RK_AW'(1) && !cnt_q[0]) rcon_q <= xtime(rcon_q);
        if (cnt_q == RK_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: sv/agcm_aes.sv
`timescale 1ns / 1ps
module agcm_aes import agcm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  agcm_req_t         req_i,
  output logic [RK_AW-1:0]  raddr_o,
  input  logic [BLK_W-1:0]  rk_i,
  output agcm_rsp_t         rsp_o
);
  // cnt_q = index of the round key arriving from memory, plus one
  logic             busy_q, done_q;
  logic [RK_AW-1:0] cnt_q;
  logic [BLK_W-1:0] blk_q, st_q, st_d;

  always_comb begin
    if (cnt_q == RK_AW'(1)) st_d = blk_q ^ rk_i;
    else                    st_d = aes_round(st_q, cnt_q == RK_LAST + RK_AW'(1)) ^ rk_i;
    if (req_i.start)                          raddr_o = '0;
    else if (cnt_q == RK_LAST + RK_AW'(1))    raddr_o = '0;
    else                                      raddr_o = cnt_q;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.data = st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        blk_q  <= req_i.data;
        cnt_q  <= RK_AW'(1);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        st_q  <= st_d;
        cnt_q <= cnt_q + RK_AW'(1);
        if (cnt_q == RK_LAST + RK_AW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: sv/agcm_ghash.sv
`timescale 1ns / 1ps
module agcm_ghash import agcm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  agcm_req_t         req_i,
  input  logic [BLK_W-1:0]  h_i,
  output agcm_rsp_t         rsp_o
);
  // eight multiplier bits per cycle, msb first
  logic             busy_q, done_q;
  logic [3:0]       cnt_q;
  logic [BLK_W-1:0] a_q, z_q, v_q, a_d, z_d, v_d;

  always_comb begin
    a_d = a_q;
    z_d = z_q;
    v_d = v_q;
    for (int j = 0; j < 8; j++) begin
      if (a_d[BLK_W-1]) z_d = z_d ^ v_d;
      v_d = {1'b0, v_d[BLK_W-1:1]} ^ (v_d[0] ? {GH_POLY, 120'd0} : '0);
      a_d = {a_d[BLK_W-2:0], 1'b0};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.data = z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        a_q    <= req_i.data;
        z_q    <= '0;
        v_q    <= h_i;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        a_q   <= a_d;
        z_q   <= z_d;
        v_q   <= v_d;
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: sv/agcm_checker.sv
`timescale 1ns / 1ps
module agcm_checker import agcm_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_high,
  input logic [63:0] out_low,
  input logic [4:0]  out_count,
  input logic        result_kind,
  input logic [1:0]  status
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_tag_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && result_kind == KIND_TAG |-> out_count == 5'd16)
    else $error("tag beat without full count");

  a_mismatch_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status == STAT_MISMATCH |-> result_kind == KIND_TAG)
    else $error("mismatch flagged on a text beat");

  a_order_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status == STAT_ORDER && result_kind == KIND_TEXT |->
      out_count == 5'd0 && out_high == 64'd0 && out_low == 64'd0)
    else $error("order fault beat carries data");
endmodule

bind aes256_gcm_seal_open agcm_checker u_agcm_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .out_valid(out_o.valid), .out_ready(out_o.ready),
  .out_high(out_o.out_high), .out_low(out_o.out_low), .out_count(out_o.out_count),
  .result_kind(out_o.result_kind), .status(out_o.status)
);
